// File: rtl/rate_limited_chunk_transfer_server_defines.svh
// Assertion macros for the rate limited chunk transfer server.
// Included by files that check their own logic; no other dependencies.
`ifndef RATE_LIMITED_CHUNK_TRANSFER_SERVER_DEFINES_SVH
`define RATE_LIMITED_CHUNK_TRANSFER_SERVER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked outside reset
`define RLCTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// next-cycle implication, checked outside reset
`define RLCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define RLCTS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define RLCTS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/rlcts_pkg.sv
// Shared types and constants of the rate limited chunk transfer server.
// No dependencies; used by all RTL modules of the block.
package rlcts_pkg;

	// chunk size in bytes, a power of two so that division is a shift
	localparam int CHUNK_PAYLOAD = 64;
	localparam int CHUNK_SHIFT   = $clog2(CHUNK_PAYLOAD);

	localparam int TIME_W      = 32;
	localparam int LEN_W       = 16;
	localparam int CNT_W       = 16;
	localparam int STAT_W      = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int NUM_BUCKETS = 3;
	localparam int NUM_STATS   = 7;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		KIND_INVALID   = 2'd0,
		KIND_HANDSHAKE = 2'd1,
		KIND_CHUNK     = 2'd2,
		KIND_TICK      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ACT_SILENT    = 2'd0,
		ACT_HANDSHAKE = 2'd1,
		ACT_CHUNK     = 2'd2
	} action_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_HS  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_CHK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_INV = 3'd4;

	// rate limiter buckets
	localparam logic [1:0] BKT_HANDSHAKE = 2'd0;
	localparam logic [1:0] BKT_CHUNK     = 2'd1;
	localparam logic [1:0] BKT_INVALID   = 2'd2;

	// statistics counter indexes
	localparam int ST_INVALID      = 0;
	localparam int ST_RATE_LIMITED = 1;
	localparam int ST_HANDSHAKES   = 2;
	localparam int ST_CHUNK_REQ    = 3;
	localparam int ST_STARTED      = 4;
	localparam int ST_COMPLETED    = 5;
	localparam int ST_TIMED_OUT    = 6;

	typedef struct packed {
		kind_t             kind;
		logic [15:0]       chunk_number;
		logic [TIME_W-1:0] now_ms;
		logic [LEN_W-1:0]  published_len;
	} req_t;

	typedef struct packed {
		action_t     action;
		logic [10:0] chunk_total;
		logic [15:0] chunk_offset;
		logic [6:0]  chunk_length;
		logic        transfer_done;
		logic        transfer_expired;
		logic        was_rate_limited;
		logic        was_invalid;
	} rsp_t;

	typedef struct packed {
		logic [CFG_W-1:0] window_ms;
		logic [CFG_W-1:0] timeout_ms;
		logic [CFG_W-1:0] limit_handshake;
		logic [CFG_W-1:0] limit_chunk;
		logic [CFG_W-1:0] limit_invalid;
	} cfg_t;

	// classified request as queued between front and back
	typedef struct packed {
		kind_t             kind;
		logic [15:0]       chunk_number;
		logic [TIME_W-1:0] now_ms;
		logic [LEN_W-1:0]  published_len;
		logic              plen_zero;
		logic [CNT_W-1:0]  plen_chunks;
		logic [LEN_W-1:0]  offset;
		logic [LEN_W:0]    offset_end;
	} item_t;

endpackage

// File: rtl/rlcts_front.sv
// Front end: accepts requests, precomputes per-request values and queues them.
// Depends on rlcts_pkg.
module rlcts_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  rlcts_pkg::req_t      req,
	output logic                 item_valid,
	input  logic                 item_pop,
	output rlcts_pkg::item_t     item
);
	import rlcts_pkg::*;

	item_t                 cls;
	logic [LEN_W:0]        plen_sum;
	item_t                 queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]     wr_ptr_q;
	logic [QPTR_W-1:0]     rd_ptr_q;
	logic [QCNT_W-1:0]     count_q;
	logic                  push;
	logic                  pop;

	// classify: chunk count of the published length and chunk byte range
	always_comb begin
		plen_sum           = {1'b0, req.published_len} + (LEN_W+1)'(CHUNK_PAYLOAD - 1);
		cls.kind           = req.kind;
		cls.chunk_number   = req.chunk_number;
		cls.now_ms         = req.now_ms;
		cls.published_len  = req.published_len;
		cls.plen_zero      = (req.published_len == '0);
		cls.plen_chunks    = CNT_W'(plen_sum >> CHUNK_SHIFT);
		cls.offset         = LEN_W'({req.chunk_number, {CHUNK_SHIFT{1'b0}}});
		cls.offset_end     = {1'b0, cls.offset} + (LEN_W+1)'(CHUNK_PAYLOAD);
	end

	assign req_stall  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push       = req_valid && !req_stall;
	assign item_valid = (count_q != '0);
	assign pop        = item_pop && item_valid;
	assign item       = queue_q[rd_ptr_q];

	// queue pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// queue storage
	always_ff @(posedge clk) begin
		if (push) queue_q[wr_ptr_q] <= cls;
	end

endmodule

// File: rtl/rlcts_back.sv
// Back end: rate limiters, transfer session, statistics and the result register.
// Depends on rlcts_pkg.
module rlcts_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rlcts_pkg::cfg_t      cfg,
	input  logic                 item_valid,
	output logic                 item_pop,
	input  rlcts_pkg::item_t     item,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rlcts_pkg::rsp_t      rsp
);
	import rlcts_pkg::*;

	logic [TIME_W-1:0] bkt_start_q [NUM_BUCKETS];
	logic [CNT_W-1:0]  bkt_count_q [NUM_BUCKETS];
	logic              sess_open_q;
	logic [LEN_W-1:0]  sess_len_q;
	logic [CNT_W-1:0]  sess_chunks_q;
	logic [TIME_W-1:0] sess_last_q;
	logic [STAT_W-1:0] stat_q [NUM_STATS];
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic              fire;
	logic              expire;
	logic              open_eff;
	logic              use_bkt;
	logic [1:0]        bsel;
	logic              restart;
	logic [CNT_W-1:0]  cnt_eff;
	logic [CFG_W-1:0]  lim;
	logic              pass;
	logic [LEN_W-1:0]  cur_len;
	logic [CNT_W-1:0]  cur_chunks;
	logic              in_range;
	logic              is_last;
	logic              len_cut;
	logic [LEN_W-1:0]  len_rem;
	logic              open_d;
	logic [LEN_W-1:0]  len_d;
	logic [CNT_W-1:0]  chunks_d;
	logic [TIME_W-1:0] last_d;
	logic [NUM_STATS-1:0] stat_inc;
	rsp_t              rsp_d;

	assign fire      = item_valid && (!rsp_valid_q || !rsp_stall);
	assign item_pop  = fire;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// decision for the item at the head of the queue
	always_comb begin
		// idle timeout comes first
		expire   = sess_open_q && ((item.now_ms - sess_last_q) >= TIME_W'(cfg.timeout_ms));
		open_eff = sess_open_q && !expire;

		case (item.kind)
			KIND_INVALID:   begin bsel = BKT_INVALID;   use_bkt = 1'b1; lim = cfg.limit_invalid;   end
			KIND_HANDSHAKE: begin bsel = BKT_HANDSHAKE; use_bkt = 1'b1; lim = cfg.limit_handshake; end
			KIND_CHUNK:     begin bsel = BKT_CHUNK;     use_bkt = 1'b1; lim = cfg.limit_chunk;     end
			default:        begin bsel = BKT_INVALID;   use_bkt = 1'b0; lim = cfg.limit_invalid;   end
		endcase

		// fixed window limiter of the selected bucket
		restart = (item.now_ms - bkt_start_q[bsel]) >= TIME_W'(cfg.window_ms);
		cnt_eff = restart ? '0 : bkt_count_q[bsel];
		pass    = (cnt_eff < lim);

		// session snapshot in effect for this item
		cur_len    = open_eff ? sess_len_q : item.published_len;
		cur_chunks = open_eff ? sess_chunks_q : item.plen_chunks;
		in_range   = (CNT_W'(item.chunk_number) < cur_chunks);
		is_last    = (CNT_W'(item.chunk_number) == cur_chunks - 1'b1);
		len_cut    = (item.offset_end > {1'b0, cur_len});
		len_rem    = cur_len - item.offset;

		rsp_d                  = '0;
		rsp_d.action           = ACT_SILENT;
		rsp_d.transfer_expired = expire;
		stat_inc               = '0;
		stat_inc[ST_TIMED_OUT] = expire;
		open_d   = open_eff;
		len_d    = expire ? '0 : sess_len_q;
		chunks_d = expire ? '0 : sess_chunks_q;
		last_d   = sess_last_q;

		if (use_bkt && !pass) begin
			stat_inc[ST_RATE_LIMITED] = 1'b1;
			rsp_d.was_rate_limited    = 1'b1;
		end

		case (item.kind)
			KIND_INVALID: begin
				stat_inc[ST_INVALID] = 1'b1;
				rsp_d.was_invalid    = 1'b1;
			end
			KIND_HANDSHAKE: begin
				if (pass) begin
					stat_inc[ST_HANDSHAKES] = 1'b1;
					rsp_d.action            = ACT_HANDSHAKE;
				end
			end
			KIND_CHUNK: begin
				if (pass) begin
					if (!open_eff && item.plen_zero) begin
						// nothing published
						stat_inc[ST_INVALID] = 1'b1;
						rsp_d.was_invalid    = 1'b1;
					end else begin
						if (!open_eff) begin
							open_d               = 1'b1;
							len_d                = item.published_len;
							chunks_d             = item.plen_chunks;
							stat_inc[ST_STARTED] = 1'b1;
						end
						last_d                 = item.now_ms;
						stat_inc[ST_CHUNK_REQ] = 1'b1;
						if (!in_range) begin
							stat_inc[ST_INVALID] = 1'b1;
							rsp_d.was_invalid    = 1'b1;
						end else begin
							rsp_d.action       = ACT_CHUNK;
							rsp_d.chunk_total  = cur_chunks[10:0];
							rsp_d.chunk_offset = item.offset;
							rsp_d.chunk_length = len_cut ? 7'(len_rem) : 7'(CHUNK_PAYLOAD);
							if (is_last) begin
								open_d                 = 1'b0;
								len_d                  = '0;
								chunks_d               = '0;
								stat_inc[ST_COMPLETED] = 1'b1;
								rsp_d.transfer_done    = 1'b1;
							end
						end
					end
				end
			end
			default: ;
		endcase
	end

	// limiter, session and statistics state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BUCKETS; b++) begin
				bkt_start_q[b] <= '0;
				bkt_count_q[b] <= '0;
			end
			for (int s = 0; s < NUM_STATS; s++) stat_q[s] <= '0;
			sess_open_q   <= 1'b0;
			sess_len_q    <= '0;
			sess_chunks_q <= '0;
			sess_last_q   <= '0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (fire) begin
				if (use_bkt) begin
					if (restart) bkt_start_q[bsel] <= item.now_ms;
					bkt_count_q[bsel] <= pass ? cnt_eff + 1'b1 : cnt_eff;
				end
				for (int s = 0; s < NUM_STATS; s++) begin
					if (stat_inc[s]) stat_q[s] <= stat_q[s] + 1'b1;
				end
				sess_open_q   <= open_d;
				sess_len_q    <= len_d;
				sess_chunks_q <= chunks_d;
				sess_last_q   <= last_d;
			end
			if (fire) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (fire) rsp_q <= rsp_d;
	end

endmodule

// File: rtl/rate_limited_chunk_transfer_server.sv
// Rate limited chunk transfer server: one decoded request per transaction on
// req, one decision per transaction on rsp, in order. A new request is taken
// every cycle in steady state while rsp is not stalled; each request is written
// into the two-entry front queue, then the back end updates limiter and session
// state and registers its decision in the result register that drives rsp.
// Configuration writes are always taken (cfg_ready is tied high) and are meant
// for idle periods only.
// Depends on rlcts_pkg, rlcts_front, rlcts_back and the defines header.
`include "rate_limited_chunk_transfer_server_defines.svh"

module rate_limited_chunk_transfer_server (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_stall,
	input  rlcts_pkg::req_t                  req,
	output logic                             rsp_valid,
	input  logic                             rsp_stall,
	output rlcts_pkg::rsp_t                  rsp,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rlcts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rlcts_pkg::CFG_W-1:0]      cfg_data
);
	import rlcts_pkg::*;

	cfg_t  cfg_q;
	item_t item;
	logic  item_valid;
	logic  item_pop;

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_ms       <= 16'd1000;
			cfg_q.timeout_ms      <= 16'd2000;
			cfg_q.limit_handshake <= 16'd8;
			cfg_q.limit_chunk     <= 16'd200;
			cfg_q.limit_invalid   <= 16'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WINDOW:    cfg_q.window_ms       <= cfg_data;
				CFG_TIMEOUT:   cfg_q.timeout_ms      <= cfg_data;
				CFG_LIMIT_HS:  cfg_q.limit_handshake <= cfg_data;
				CFG_LIMIT_CHK: cfg_q.limit_chunk     <= cfg_data;
				CFG_LIMIT_INV: cfg_q.limit_invalid   <= cfg_data;
				default: ;
			endcase
		end
	end

	rlcts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item)
	);

	rlcts_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_pop   (item_pop),
		.item       (item),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

	// result consistency checks
	`RLCTS_ASSERT_IMPLIES(a_done_is_chunk, clk, arst_n, rsp_valid && rsp.transfer_done, rsp.action == ACT_CHUNK)
	`RLCTS_ASSERT_IMPLIES(a_limited_silent, clk, arst_n, rsp_valid && rsp.was_rate_limited, rsp.action == ACT_SILENT)
	`RLCTS_ASSERT_IMPLIES(a_chunk_nonempty, clk, arst_n, rsp_valid && (rsp.action == ACT_CHUNK), (rsp.chunk_length != '0) && (rsp.chunk_total != '0))
	`RLCTS_ASSERT_IMPLIES(a_idle_fields_zero, clk, arst_n, rsp_valid && (rsp.action != ACT_CHUNK), (rsp.chunk_total == '0) && (rsp.chunk_offset == '0) && (rsp.chunk_length == '0))

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the rate limited chunk transfer server.
// Predicts every decision from its own model of limiters and session state;
// depends only on rlcts_pkg and the top level of the block.
`timescale 1ns / 1ps

module testbench;
	import rlcts_pkg::*;

	localparam int HOLD_CYCLES = 80;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req       = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;

	rate_limited_chunk_transfer_server dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model copy of configuration and state, reset values
	logic [15:0] win_ms  = 16'd1000;
	logic [15:0] tmo_ms  = 16'd2000;
	logic [15:0] lim_hs  = 16'd8;
	logic [15:0] lim_chk = 16'd200;
	logic [15:0] lim_inv = 16'd32;
	logic [31:0] bkt_start [NUM_BUCKETS] = '{default: '0};
	logic [15:0] bkt_count [NUM_BUCKETS] = '{default: '0};
	logic        sess_open   = 1'b0;
	logic [15:0] sess_len    = '0;
	logic [15:0] sess_chunks = '0;
	logic [31:0] sess_last   = '0;
	logic [31:0] stats [NUM_STATS] = '{default: '0};

	req_t        pending_reqs [$];
	rsp_t        open_results [$];
	int unsigned req_issued      = 0;
	int unsigned req_accepts     = 0;
	int unsigned queued_items    = 0;
	int unsigned results_checked = 0;
	int unsigned fail_count      = 0;
	int unsigned config_count    = 0;
	int unsigned gap_pct         = 13;
	int unsigned hold_req        = 0;
	int unsigned hold_seen       = 0;
	int unsigned hold_left       = 0;
	logic [31:0] clock_ms        = '0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#3_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	// fixed-window limiter: restart the window when it has aged out
	function automatic bit bucket_grant(logic [1:0] b, logic [31:0] now, logic [15:0] limit);
		logic [31:0] age;
		age = now - bkt_start[b];
		if (age >= win_ms) begin
			bkt_start[b] = now;
			bkt_count[b] = '0;
		end
		if (bkt_count[b] >= limit) begin
			stats[ST_RATE_LIMITED]++;
			return 1'b0;
		end
		bkt_count[b]++;
		return 1'b1;
	endfunction

	function automatic void end_session(bit completed);
		sess_open   = 1'b0;
		sess_len    = '0;
		sess_chunks = '0;
		if (completed)
			stats[ST_COMPLETED]++;
		else
			stats[ST_TIMED_OUT]++;
	endfunction

	// decision for one request, updating the model state
	function automatic rsp_t serve_request(req_t r);
		rsp_t        o;
		logic [31:0] idle;
		logic [31:0] offs;
		logic [31:0] blen;
		o = '0;
		idle = r.now_ms - sess_last;
		if (sess_open && idle >= tmo_ms) begin
			end_session(1'b0);
			o.transfer_expired = 1'b1;
		end
		case (r.kind)
			KIND_INVALID: begin
				stats[ST_INVALID]++;
				o.was_invalid = 1'b1;
				if (!bucket_grant(BKT_INVALID, r.now_ms, lim_inv))
					o.was_rate_limited = 1'b1;
			end
			KIND_HANDSHAKE: begin
				if (!bucket_grant(BKT_HANDSHAKE, r.now_ms, lim_hs)) begin
					o.was_rate_limited = 1'b1;
				end else begin
					stats[ST_HANDSHAKES]++;
					o.action = ACT_HANDSHAKE;
				end
			end
			KIND_CHUNK: begin
				if (!bucket_grant(BKT_CHUNK, r.now_ms, lim_chk)) begin
					o.was_rate_limited = 1'b1;
				end else if (!sess_open && r.published_len == '0) begin
					// nothing published to serve
					stats[ST_INVALID]++;
					o.was_invalid = 1'b1;
				end else begin
					if (!sess_open) begin
						sess_open   = 1'b1;
						sess_len    = r.published_len;
						sess_chunks = 16'((r.published_len + CHUNK_PAYLOAD - 1) / CHUNK_PAYLOAD);
						stats[ST_STARTED]++;
					end
					sess_last = r.now_ms;
					stats[ST_CHUNK_REQ]++;
					if (r.chunk_number >= sess_chunks) begin
						stats[ST_INVALID]++;
						o.was_invalid = 1'b1;
					end else begin
						offs = r.chunk_number * CHUNK_PAYLOAD;
						blen = CHUNK_PAYLOAD;
						if (offs + blen > sess_len)
							blen = sess_len - offs;
						o.action       = ACT_CHUNK;
						o.chunk_total  = sess_chunks[10:0];
						o.chunk_offset = offs[15:0];
						o.chunk_length = blen[6:0];
						if (r.chunk_number == sess_chunks - 1) begin
							end_session(1'b1);
							o.transfer_done = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic void note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	// request driver: next transaction once the current one is taken
	always @(negedge clk) begin
		if (arst_n && (!req_valid || req_accepts == req_issued)) begin
			if (pending_reqs.size() != 0 && $urandom_range(99) >= gap_pct) begin
				req       <= pending_reqs.pop_front();
				req_valid <= 1'b1;
				req_issued++;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// response side: random stalls plus an occasional long hold-off
	always @(negedge clk) begin
		if (hold_left != 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			rsp_stall <= 1'b1;
			hold_seen <= hold_seen + 1;
			hold_left <= HOLD_CYCLES;
		end else begin
			rsp_stall <= ($urandom_range(99) < gap_pct);
		end
	end

	// monitor: register writes, accepted requests, checked responses
	always @(posedge clk) begin : monitor
		rsp_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_WINDOW:    win_ms  = cfg_data;
					CFG_TIMEOUT:   tmo_ms  = cfg_data;
					CFG_LIMIT_HS:  lim_hs  = cfg_data;
					CFG_LIMIT_CHK: lim_chk = cfg_data;
					CFG_LIMIT_INV: lim_inv = cfg_data;
					default: ;
				endcase
			end
			if (req_valid && !req_stall) begin
				open_results.push_back(serve_request(req));
				req_accepts++;
			end
			if (rsp_valid && !rsp_stall) begin
				if (open_results.size() == 0) begin
					note_failure("response transaction with no request outstanding");
				end else begin
					want = open_results.pop_front();
					results_checked++;
					if (rsp.action !== want.action || rsp.chunk_total !== want.chunk_total ||
						rsp.chunk_offset !== want.chunk_offset ||
						rsp.chunk_length !== want.chunk_length ||
						rsp.transfer_done !== want.transfer_done ||
						rsp.transfer_expired !== want.transfer_expired ||
						rsp.was_rate_limited !== want.was_rate_limited ||
						rsp.was_invalid !== want.was_invalid)
						note_failure($sformatf({"response %0d: expected act %0d tot %0d off %0d ",
							"len %0d dn %b exp %b lim %b inv %b, got act %0d tot %0d off %0d ",
							"len %0d dn %b exp %b lim %b inv %b"}, results_checked,
							want.action, want.chunk_total, want.chunk_offset, want.chunk_length,
							want.transfer_done, want.transfer_expired, want.was_rate_limited,
							want.was_invalid, rsp.action, rsp.chunk_total, rsp.chunk_offset,
							rsp.chunk_length, rsp.transfer_done, rsp.transfer_expired,
							rsp.was_rate_limited, rsp.was_invalid));
				end
			end
		end
	end

	task automatic push_req(kind_t k, logic [15:0] idx, logic [31:0] now, logic [15:0] plen);
		req_t r;
		r.kind          = k;
		r.chunk_number  = idx;
		r.now_ms        = now;
		r.published_len = plen;
		pending_reqs.push_back(r);
		queued_items++;
	endtask

	// timestamps: mostly small steps, sometimes past the timeout, rarely anywhere
	function automatic logic [31:0] next_stamp();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 35)
			;
		else if (r < 75)
			clock_ms += $urandom_range(win_ms / 8 + 1);
		else if (r < 90)
			clock_ms += $urandom_range(win_ms + tmo_ms);
		else if (r < 97)
			clock_ms += $urandom_range(2 * tmo_ms + 2, tmo_ms);
		else
			clock_ms = $urandom();
		return clock_ms;
	endfunction

	task automatic push_noise();
		push_req(kind_t'($urandom_range(3)), 16'($urandom()), next_stamp(),
			($urandom_range(2) == 0) ? 16'd0 : 16'($urandom()));
	endtask

	// one transfer: optional handshake, opening chunk, a few more, then the last
	task automatic push_transfer();
		int unsigned plen, chunks, steps, j, r;
		logic [15:0] idx;
		r = $urandom_range(99);
		if (r < 8)
			plen = $urandom_range(65535, 1);
		else if (r < 20)
			plen = CHUNK_PAYLOAD * $urandom_range(12, 1);
		else
			plen = $urandom_range(700, 1);
		chunks = (plen + CHUNK_PAYLOAD - 1) / CHUNK_PAYLOAD;
		if ($urandom_range(1) == 1)
			push_req(KIND_HANDSHAKE, 16'($urandom()), next_stamp(), 16'($urandom()));
		idx = ($urandom_range(3) == 0) ? 16'($urandom_range(chunks - 1)) : 16'd0;
		push_req(KIND_CHUNK, idx, next_stamp(), 16'(plen));
		steps = $urandom_range(8);
		for (j = 1; j <= steps && j < chunks - 1; j++) begin
			r = $urandom_range(99);
			if (r < 80)
				idx = 16'(j);
			else if (r < 90)
				idx = 16'(chunks + $urandom_range(40));
			else
				idx = 16'($urandom());
			if ($urandom_range(9) == 0)
				push_noise();
			push_req(KIND_CHUNK, idx, next_stamp(),
				($urandom_range(1) == 1) ? 16'(plen) : 16'($urandom()));
		end
		// some transfers are left open to age out
		if ($urandom_range(99) < 85)
			push_req(KIND_CHUNK, 16'(chunks - 1), next_stamp(), 16'($urandom()));
	endtask

	task automatic fill_items(int unsigned n);
		int unsigned target;
		target = queued_items + n;
		while (queued_items < target) begin
			if ($urandom_range(99) < 65)
				push_transfer();
			else
				push_noise();
		end
	endtask

	// sender pause: everything issued, taken and answered
	task automatic wait_idle();
		while (pending_reqs.size() != 0 || req_accepts != req_issued || open_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_config(logic [15:0] w, t, h, c, i);
		write_reg(CFG_WINDOW, w);
		write_reg(CFG_TIMEOUT, t);
		write_reg(CFG_LIMIT_HS, h);
		write_reg(CFG_LIMIT_CHK, c);
		write_reg(CFG_LIMIT_INV, i);
		@(negedge clk);
		config_count++;
	endtask

	task automatic run_phase(logic [15:0] w, t, h, c, i, int unsigned n, bit squeeze);
		set_config(w, t, h, c, i);
		if (squeeze)
			hold_req++;
		fill_items(n / 2);
		wait_idle();
		fill_items(n - n / 2);
		wait_idle();
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		// directed: reset settings, field extremes and each corner of the session
		push_req(KIND_INVALID, 16'hFFFF, 32'd0, 16'hFFFF);
		push_req(KIND_TICK, 16'd0, 32'hFFFF_FFFF, 16'd0);
		push_req(KIND_HANDSHAKE, 16'd0, 32'd10, 16'd0);
		push_req(KIND_CHUNK, 16'd0, 32'd20, 16'd0);       // nothing published
		push_req(KIND_CHUNK, 16'd0, 32'd30, 16'd130);     // opens, three chunks
		push_req(KIND_CHUNK, 16'd5, 32'd40, 16'd130);     // index out of range
		push_req(KIND_CHUNK, 16'd1, 32'd50, 16'd0);
		push_req(KIND_CHUNK, 16'd2, 32'd60, 16'd0);       // short last chunk
		push_req(KIND_CHUNK, 16'd0, 32'd70, 16'd64);      // single full chunk
		push_req(KIND_CHUNK, 16'd1023, 32'd80, 16'hFFFF); // largest descriptor
		push_req(KIND_CHUNK, 16'd3, 32'd100, 16'd300);
		push_req(KIND_CHUNK, 16'hFFFF, 32'd200, 16'd0);
		push_req(KIND_TICK, 16'd0, 32'd2199, 16'd0);      // one short of timeout
		push_req(KIND_TICK, 16'd0, 32'd2200, 16'd0);      // idle timeout
		repeat (10) push_req(KIND_HANDSHAKE, 16'd0, 32'd3000, 16'd0);
		push_req(KIND_HANDSHAKE, 16'd0, 32'd3999, 16'd0);
		push_req(KIND_HANDSHAKE, 16'd0, 32'd4000, 16'd0); // fresh window
		push_req(KIND_CHUNK, 16'd0, 32'hFFFF_FFF0, 16'd100);
		push_req(KIND_CHUNK, 16'd1, 32'h0000_0100, 16'd0); // across time wrap
		wait_idle();

		// zero window and zero timeout
		set_config(16'd0, 16'd0, 16'd1, 16'hFFFF, 16'd0);
		push_req(KIND_CHUNK, 16'd0, 32'd5000, 16'd200);
		push_req(KIND_TICK, 16'd0, 32'd5000, 16'd0);
		push_req(KIND_HANDSHAKE, 16'd0, 32'd5000, 16'd0);
		push_req(KIND_HANDSHAKE, 16'd0, 32'd5000, 16'd0);
		push_req(KIND_INVALID, 16'd0, 32'd5000, 16'd0);
		wait_idle();

		// random phases over a range of settings
		clock_ms = 32'hFFFF_E000;
		run_phase(16'd300, 16'd700, 16'd4, 16'd12, 16'd6, 140, 1'b0);
		run_phase(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 150, 1'b1);
		run_phase(16'd1, 16'd1, 16'd0, 16'd0, 16'd0, 50, 1'b0);
		run_phase(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 60, 1'b0);
		run_phase(16'($urandom_range(65535, 1)), 16'($urandom_range(65535, 1)),
			16'($urandom_range(65535)), 16'($urandom_range(65535)),
			16'($urandom_range(65535)), 100, 1'b0);
		gap_pct = 0;
		run_phase(16'd1000, 16'd2000, 16'd8, 16'd200, 16'd32, 150, 1'b0);
		gap_pct = 13;
		run_phase(16'($urandom_range(2000, 20)), 16'($urandom_range(3000, 50)),
			16'($urandom_range(30, 1)), 16'($urandom_range(400, 20)),
			16'($urandom_range(40, 1)), 100, 1'b1);

		wait_idle();
		repeat (8) @(negedge clk);
		if (open_results.size() != 0)
			note_failure($sformatf("%0d responses never arrived", open_results.size()));

		$display("Run: %0d requests under %0d register settings, %0d responses checked.",
			queued_items, config_count, results_checked);
		$display("Transfers %0d started, %0d completed, %0d timed out; %0d rate limited, %0d invalid.",
			stats[ST_STARTED], stats[ST_COMPLETED], stats[ST_TIMED_OUT],
			stats[ST_RATE_LIMITED], stats[ST_INVALID]);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
